[src/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros shared by the lane line fit RTL
// Clocked on clk; the first form is masked while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property outside of reset
`define LSF_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a property on every edge, reset included
`define LSF_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[src/lsf_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsf_pkg
// Types, widths and the fit program shared by the lane line fit modules.
// ----------------------------------------------------------------------------
package lsf_pkg;

  // Capacity and coordinate width
  localparam int MAX_POINTS = 1024;
  localparam int COORD_BITS = 11;
  localparam int FIELD_W    = 11;
  localparam int CFG_W      = 11;
  localparam int SLOPE_W    = 16;
  localparam int XOUT_W     = 16;
  localparam int CFG_AW     = 4;
  localparam int CFG_DW     = 32;

  // Accumulator and fit widths
  localparam int CNT_W  = $clog2(MAX_POINTS + 1);
  localparam int SUM_W  = CNT_W + COORD_BITS;
  localparam int SQ_W   = CNT_W + 2 * COORD_BITS;
  localparam int DN_W   = CNT_W + SQ_W + 1;
  localparam int MAG_W  = DN_W - 1;
  localparam int B_W    = CNT_W + COORD_BITS;
  localparam int ACC_W  = B_W + DN_W + 2;
  localparam int NUM_W  = ACC_W - 1;
  localparam int DV_W   = CNT_W + DN_W;
  localparam int QCNT_W = $clog2(NUM_W + 1);
  localparam int CMP_W  = ((COORD_BITS + 1) > CFG_W) ? (COORD_BITS + 1) : CFG_W;
  localparam int KW     = COORD_BITS + SLOPE_W;

  // Vertical segment counts as slope 999 in Q10.8
  localparam int VERT_SLOPE_Q8 = 999 * 256;
  localparam int X_POS_MAX     = 32767;
  localparam int X_NEG_MAG     = 32768;

  // Fit program layout
  localparam int STEP_W       = 6;
  localparam int STEP_CHECK   = 8;
  localparam int ROW_BASE     = 9;
  localparam int ROW_TOP_BASE = 22;
  localparam int STEP_LAST    = 34;

  typedef struct packed {
    logic [FIELD_W-1:0] x_start;
    logic [FIELD_W-1:0] y_start;
    logic [FIELD_W-1:0] x_end;
    logic [FIELD_W-1:0] y_end;
    logic               frame_last;
  } in_item_t;

  typedef struct packed {
    logic                     right_found;
    logic signed [XOUT_W-1:0] right_x_bottom;
    logic signed [XOUT_W-1:0] right_x_top;
    logic                     left_found;
    logic signed [XOUT_W-1:0] left_x_bottom;
    logic signed [XOUT_W-1:0] left_x_top;
    logic                     points_overflow;
  } out_item_t;

  typedef struct packed {
    logic [CFG_W-1:0]   frame_width;
    logic [CFG_W-1:0]   frame_height;
    logic [CFG_W-1:0]   top_row;
    logic [SLOPE_W-1:0] slope_limit;
  } cfg_t;

  typedef enum logic [1:0] {
    REG_FRAME_WIDTH,
    REG_FRAME_HEIGHT,
    REG_TOP_ROW,
    REG_SLOPE_LIMIT
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CLASSIFY,
    ST_ISSUE,
    ST_WAIT,
    ST_DONE
  } ctrl_state_t;

  typedef enum logic [3:0] {
    OP_NOP,
    OP_CLR,
    OP_MUL,
    OP_SAVE_D,
    OP_SAVE_N,
    OP_CHECK,
    OP_SAVE_T,
    OP_SAVE_NUM,
    OP_SAVE_DIV,
    OP_DIV,
    OP_STORE
  } fit_op_t;

  typedef enum logic [2:0] {
    A_N,
    A_SX,
    A_SY,
    A_SXX,
    A_SXY,
    A_D,
    A_NMAG
  } a_sel_t;

  typedef enum logic [2:0] {
    B_N,
    B_SX,
    B_SY,
    B_ROW,
    B_T
  } b_sel_t;

  typedef enum logic [1:0] {
    SG_ADD,
    SG_SUB,
    SG_NSIGN
  } sgn_t;

  typedef struct packed {
    fit_op_t op;
    a_sel_t  a_sel;
    b_sel_t  b_sel;
    sgn_t    sgn;
    logic    row_top;
  } fit_cmd_t;

  typedef struct packed {
    logic     load_in;
    logic     classify;
    logic     fit_go;
    fit_cmd_t fit;
    logic     side;
    logic     emit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic last;
    logic busy;
    logic skip;
    logic out_free;
  } dp_status_t;

  // Build one fit command: D and N first, then the row evaluation twice
  function automatic fit_cmd_t mk(fit_op_t op, a_sel_t a, b_sel_t b, sgn_t s,
                                  logic top);
    fit_cmd_t c;
    c.op      = op;
    c.a_sel   = a;
    c.b_sel   = b;
    c.sgn     = s;
    c.row_top = top;
    return c;
  endfunction

  function automatic fit_cmd_t prog_cmd(logic [STEP_W-1:0] step);
    fit_cmd_t          c;
    logic              top;
    logic [STEP_W-1:0] k;
    c   = mk(OP_NOP, A_N, B_N, SG_ADD, 1'b0);
    top = (step >= STEP_W'(ROW_TOP_BASE));
    k   = top ? step - STEP_W'(ROW_TOP_BASE) : step - STEP_W'(ROW_BASE);
    if (step < STEP_W'(ROW_BASE)) begin
      unique case (step)
        6'd0:    c = mk(OP_CLR,    A_N,   B_N,  SG_ADD, 1'b0);
        6'd1:    c = mk(OP_MUL,    A_SXX, B_N,  SG_ADD, 1'b0);
        6'd2:    c = mk(OP_MUL,    A_SX,  B_SX, SG_SUB, 1'b0);
        6'd3:    c = mk(OP_SAVE_D, A_N,   B_N,  SG_ADD, 1'b0);
        6'd4:    c = mk(OP_CLR,    A_N,   B_N,  SG_ADD, 1'b0);
        6'd5:    c = mk(OP_MUL,    A_SXY, B_N,  SG_ADD, 1'b0);
        6'd6:    c = mk(OP_MUL,    A_SY,  B_SX, SG_SUB, 1'b0);
        6'd7:    c = mk(OP_SAVE_N, A_N,   B_N,  SG_ADD, 1'b0);
        6'd8:    c = mk(OP_CHECK,  A_N,   B_N,  SG_ADD, 1'b0);
        default: c = mk(OP_NOP,    A_N,   B_N,  SG_ADD, 1'b0);
      endcase
    end else begin
      unique case (k)
        6'd0:    c = mk(OP_CLR,      A_N,    B_N,   SG_ADD,   top);
        6'd1:    c = mk(OP_MUL,      A_N,    B_ROW, SG_ADD,   top);
        6'd2:    c = mk(OP_SAVE_T,   A_N,    B_N,   SG_ADD,   top);
        6'd3:    c = mk(OP_CLR,      A_N,    B_N,   SG_ADD,   top);
        6'd4:    c = mk(OP_MUL,      A_D,    B_T,   SG_ADD,   top);
        6'd5:    c = mk(OP_MUL,      A_D,    B_SY,  SG_SUB,   top);
        6'd6:    c = mk(OP_MUL,      A_NMAG, B_SX,  SG_NSIGN, top);
        6'd7:    c = mk(OP_SAVE_NUM, A_N,    B_N,   SG_ADD,   top);
        6'd8:    c = mk(OP_CLR,      A_N,    B_N,   SG_ADD,   top);
        6'd9:    c = mk(OP_MUL,      A_NMAG, B_N,   SG_ADD,   top);
        6'd10:   c = mk(OP_SAVE_DIV, A_N,    B_N,   SG_ADD,   top);
        6'd11:   c = mk(OP_DIV,      A_N,    B_N,   SG_ADD,   top);
        6'd12:   c = mk(OP_STORE,    A_N,    B_N,   SG_ADD,   top);
        default: c = mk(OP_NOP,      A_N,    B_N,   SG_ADD,   top);
      endcase
    end
    return c;
  endfunction

endpackage

[src/lsf_cfg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsf_cfg
// Configuration register file behind an APB-style port.
// ----------------------------------------------------------------------------
module lsf_cfg (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_psel,
  input  logic                        cfg_penable,
  input  logic                        cfg_pwrite,
  input  logic [lsf_pkg::CFG_AW-1:0]  cfg_paddr,
  input  logic [lsf_pkg::CFG_DW-1:0]  cfg_pwdata,
  output logic [lsf_pkg::CFG_DW-1:0]  cfg_prdata,
  output logic                        cfg_pready,
  output lsf_pkg::cfg_t               cfg
);

  lsf_pkg::cfg_t    cfg_r;
  lsf_pkg::cfg_reg_t reg_sel;
  logic             wr_en;

  assign reg_sel    = lsf_pkg::cfg_reg_t'(cfg_paddr[lsf_pkg::CFG_AW-1:2]);
  assign wr_en      = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_pready = 1'b1;
  assign cfg        = cfg_r;

  // Write the addressed register, restore defaults on reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.frame_width  <= lsf_pkg::CFG_W'(640);
      cfg_r.frame_height <= lsf_pkg::CFG_W'(480);
      cfg_r.top_row      <= lsf_pkg::CFG_W'(288);
      cfg_r.slope_limit  <= lsf_pkg::SLOPE_W'(128);
    end else if (wr_en) begin
      unique case (reg_sel)
        lsf_pkg::REG_FRAME_WIDTH:  cfg_r.frame_width  <= cfg_pwdata[lsf_pkg::CFG_W-1:0];
        lsf_pkg::REG_FRAME_HEIGHT: cfg_r.frame_height <= cfg_pwdata[lsf_pkg::CFG_W-1:0];
        lsf_pkg::REG_TOP_ROW:      cfg_r.top_row      <= cfg_pwdata[lsf_pkg::CFG_W-1:0];
        lsf_pkg::REG_SLOPE_LIMIT:  cfg_r.slope_limit  <= cfg_pwdata[lsf_pkg::SLOPE_W-1:0];
      endcase
    end
  end

  // Read back the addressed register
  always_comb begin
    unique case (reg_sel)
      lsf_pkg::REG_FRAME_WIDTH:  cfg_prdata = lsf_pkg::CFG_DW'(cfg_r.frame_width);
      lsf_pkg::REG_FRAME_HEIGHT: cfg_prdata = lsf_pkg::CFG_DW'(cfg_r.frame_height);
      lsf_pkg::REG_TOP_ROW:      cfg_prdata = lsf_pkg::CFG_DW'(cfg_r.top_row);
      lsf_pkg::REG_SLOPE_LIMIT:  cfg_prdata = lsf_pkg::CFG_DW'(cfg_r.slope_limit);
    endcase
  end

endmodule

[src/lsf_div.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsf_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module lsf_div (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [lsf_pkg::NUM_W-1:0]  num,
  input  logic [lsf_pkg::DV_W-1:0]   den,
  output logic                       busy,
  output logic [lsf_pkg::NUM_W-1:0]  quo
);

  logic [lsf_pkg::QCNT_W-1:0] cnt_r;
  logic [lsf_pkg::DV_W-1:0]   rem_r;
  logic [lsf_pkg::NUM_W-1:0]  nq_r;
  logic [lsf_pkg::DV_W-1:0]   den_r;
  logic [lsf_pkg::DV_W:0]     rem_sh;
  logic [lsf_pkg::DV_W:0]     rem_sub;
  logic                       q_bit;

  assign busy    = (cnt_r != '0);
  assign quo     = nq_r;
  assign rem_sh  = {rem_r, nq_r[lsf_pkg::NUM_W-1]};
  assign rem_sub = rem_sh - {1'b0, den_r};
  assign q_bit   = (rem_sh >= {1'b0, den_r});

  // Count the iterations
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (start) begin
      cnt_r <= lsf_pkg::QCNT_W'(lsf_pkg::NUM_W);
    end else if (busy) begin
      cnt_r <= cnt_r - 1'b1;
    end
  end

  // Shift the dividend out and the quotient in
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      nq_r  <= num;
      den_r <= den;
    end else if (busy) begin
      rem_r <= q_bit ? rem_sub[lsf_pkg::DV_W-1:0] : rem_sh[lsf_pkg::DV_W-1:0];
      nq_r  <= {nq_r[lsf_pkg::NUM_W-2:0], q_bit};
    end
  end

endmodule

[src/lsf_dp.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsf_dp
// Datapath: segment filter, per-side sums, shift-add fit engine and result.
// ----------------------------------------------------------------------------
module lsf_dp (
  input  logic                 clk,
  input  logic                 rst_n,
  input  lsf_pkg::in_item_t    in_data,
  input  lsf_pkg::cfg_t        cfg,
  input  lsf_pkg::ctrl_cmd_t   cmd,
  input  logic                 out_stall,
  output lsf_pkg::dp_status_t  status,
  output logic                 out_valid,
  output lsf_pkg::out_item_t   out_data
);

  localparam int CB = lsf_pkg::COORD_BITS;

  lsf_pkg::in_item_t in_r;

  logic [lsf_pkg::CNT_W-1:0] cnt_r [2];
  logic [lsf_pkg::SUM_W-1:0] sx_r  [2];
  logic [lsf_pkg::SUM_W-1:0] sy_r  [2];
  logic [lsf_pkg::SQ_W-1:0]  sxx_r [2];
  logic [lsf_pkg::SQ_W-1:0]  sxy_r [2];
  logic                      ovf_r;

  // Segment filter signals
  logic [CB-1:0]               x1, y1, x2, y2;
  logic signed [CB:0]          dx, dy;
  logic [CB-1:0]               adx, ady;
  logic [lsf_pkg::KW-1:0]      lhs, rhs;
  logic                        kept, pos, hit_r, hit_l, full;
  logic [lsf_pkg::CMP_W-1:0]   x1_2, x2_2, fw;
  logic [lsf_pkg::CNT_W:0]     cnt_add;
  logic                        wsel;

  // Fit engine signals
  logic signed [lsf_pkg::ACC_W-1:0] acc_r, acc_abs;
  logic [lsf_pkg::ACC_W-1:0]        ma_r, a_val;
  logic [lsf_pkg::B_W-1:0]          mb_r, b_val;
  logic                             msub_r, sub_val, mac_busy;
  logic signed [lsf_pkg::DN_W-1:0]  d_r;
  logic [lsf_pkg::MAG_W-1:0]        nmag_r;
  logic                             nneg_r;
  logic [lsf_pkg::B_W-1:0]          t_r;
  logic [lsf_pkg::NUM_W-1:0]        num_mag_r;
  logic                             num_neg_r;
  logic [lsf_pkg::DV_W-1:0]         dvs_r;
  logic                             div_start, div_busy;
  logic [lsf_pkg::NUM_W-1:0]        quo;
  logic [lsf_pkg::CNT_W-1:0]        n_sel;
  logic [lsf_pkg::SUM_W-1:0]        sx_sel, sy_sel;
  logic [lsf_pkg::SQ_W-1:0]         sxx_sel, sxy_sel;
  logic [lsf_pkg::CFG_W-1:0]        row_val;
  logic signed [lsf_pkg::XOUT_W-1:0] x_sat;
  logic                             res_neg;

  logic                              found_r [2];
  logic signed [lsf_pkg::XOUT_W-1:0] xres_r  [2][2];

  logic               out_valid_r;
  lsf_pkg::out_item_t out_r;
  logic               op_go;
  lsf_pkg::fit_op_t   op;

  assign op    = cmd.fit.op;
  assign op_go = cmd.fit_go;

  // Hold the accepted request
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      in_r <= in_data;
    end
  end

  // Slope test by cross-multiplication and side choice
  always_comb begin
    x1   = in_r.x_start[CB-1:0];
    y1   = in_r.y_start[CB-1:0];
    x2   = in_r.x_end[CB-1:0];
    y2   = in_r.y_end[CB-1:0];
    dx   = $signed({1'b0, x2}) - $signed({1'b0, x1});
    dy   = $signed({1'b0, y2}) - $signed({1'b0, y1});
    adx  = dx[CB] ? CB'(-dx) : dx[CB-1:0];
    ady  = dy[CB] ? CB'(-dy) : dy[CB-1:0];
    lhs  = lsf_pkg::KW'({ady, 8'h00});
    rhs  = lsf_pkg::KW'(cfg.slope_limit) * lsf_pkg::KW'(adx);
    if (dx == '0) begin
      kept = (lsf_pkg::KW'(lsf_pkg::VERT_SLOPE_Q8) > lsf_pkg::KW'(cfg.slope_limit));
      pos  = 1'b1;
    end else begin
      kept = (lhs > rhs);
      pos  = ((dy > 0) == (dx > 0));
    end
    x1_2  = lsf_pkg::CMP_W'({x1, 1'b0});
    x2_2  = lsf_pkg::CMP_W'({x2, 1'b0});
    fw    = lsf_pkg::CMP_W'(cfg.frame_width);
    hit_r = kept && pos && (x1_2 > fw) && (x2_2 > fw);
    hit_l = kept && !pos && (x1_2 < fw) && (x2_2 < fw);
    wsel  = !hit_r;
    cnt_add = (wsel ? {1'b0, cnt_r[1]} : {1'b0, cnt_r[0]}) + (lsf_pkg::CNT_W+1)'(2);
    full  = (cnt_add > (lsf_pkg::CNT_W+1)'(lsf_pkg::MAX_POINTS));
  end

  // Accumulate the kept endpoints, clear after each frame
  always_ff @(posedge clk) begin
    if (!rst_n || cmd.emit) begin
      for (int s = 0; s < 2; s++) begin
        cnt_r[s] <= '0;
        sx_r[s]  <= '0;
        sy_r[s]  <= '0;
        sxx_r[s] <= '0;
        sxy_r[s] <= '0;
      end
      ovf_r <= 1'b0;
    end else if (cmd.classify && (hit_r || hit_l)) begin
      if (full) begin
        ovf_r <= 1'b1;
      end else begin
        cnt_r[wsel] <= cnt_add[lsf_pkg::CNT_W-1:0];
        sx_r[wsel]  <= sx_r[wsel] + lsf_pkg::SUM_W'(x1) + lsf_pkg::SUM_W'(x2);
        sy_r[wsel]  <= sy_r[wsel] + lsf_pkg::SUM_W'(y1) + lsf_pkg::SUM_W'(y2);
        sxx_r[wsel] <= sxx_r[wsel] + lsf_pkg::SQ_W'((2*CB)'(x1) * (2*CB)'(x1))
                                   + lsf_pkg::SQ_W'((2*CB)'(x2) * (2*CB)'(x2));
        sxy_r[wsel] <= sxy_r[wsel] + lsf_pkg::SQ_W'((2*CB)'(x1) * (2*CB)'(y1))
                                   + lsf_pkg::SQ_W'((2*CB)'(x2) * (2*CB)'(y2));
      end
    end
  end

  // Select the side under fit
  always_comb begin
    n_sel   = cmd.side ? cnt_r[1] : cnt_r[0];
    sx_sel  = cmd.side ? sx_r[1]  : sx_r[0];
    sy_sel  = cmd.side ? sy_r[1]  : sy_r[0];
    sxx_sel = cmd.side ? sxx_r[1] : sxx_r[0];
    sxy_sel = cmd.side ? sxy_r[1] : sxy_r[0];
    row_val = cmd.fit.row_top ? cfg.top_row : cfg.frame_height;
  end

  // Multiplicand, multiplier and sign of the next product
  always_comb begin
    unique case (cmd.fit.a_sel)
      lsf_pkg::A_N:    a_val = lsf_pkg::ACC_W'(n_sel);
      lsf_pkg::A_SX:   a_val = lsf_pkg::ACC_W'(sx_sel);
      lsf_pkg::A_SY:   a_val = lsf_pkg::ACC_W'(sy_sel);
      lsf_pkg::A_SXX:  a_val = lsf_pkg::ACC_W'(sxx_sel);
      lsf_pkg::A_SXY:  a_val = lsf_pkg::ACC_W'(sxy_sel);
      lsf_pkg::A_D:    a_val = lsf_pkg::ACC_W'(d_r[lsf_pkg::MAG_W-1:0]);
      lsf_pkg::A_NMAG: a_val = lsf_pkg::ACC_W'(nmag_r);
      default:         a_val = '0;
    endcase
    unique case (cmd.fit.b_sel)
      lsf_pkg::B_N:   b_val = lsf_pkg::B_W'(n_sel);
      lsf_pkg::B_SX:  b_val = lsf_pkg::B_W'(sx_sel);
      lsf_pkg::B_SY:  b_val = lsf_pkg::B_W'(sy_sel);
      lsf_pkg::B_ROW: b_val = lsf_pkg::B_W'(row_val);
      lsf_pkg::B_T:   b_val = t_r;
      default:        b_val = '0;
    endcase
    unique case (cmd.fit.sgn)
      lsf_pkg::SG_ADD:   sub_val = 1'b0;
      lsf_pkg::SG_SUB:   sub_val = 1'b1;
      lsf_pkg::SG_NSIGN: sub_val = nneg_r;
      default:           sub_val = 1'b0;
    endcase
  end

  assign mac_busy = (mb_r != '0);
  assign acc_abs  = acc_r[lsf_pkg::ACC_W-1] ? -acc_r : acc_r;

  // Shift-add multiply-accumulate, one multiplier bit per cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mb_r <= '0;
    end else if (op_go && op == lsf_pkg::OP_MUL) begin
      mb_r <= b_val;
    end else if (mac_busy) begin
      mb_r <= mb_r >> 1;
    end
  end

  always_ff @(posedge clk) begin
    if (op_go && op == lsf_pkg::OP_MUL) begin
      ma_r   <= a_val;
      msub_r <= sub_val;
    end else if (mac_busy) begin
      ma_r <= ma_r << 1;
    end
    if (op_go && op == lsf_pkg::OP_CLR) begin
      acc_r <= '0;
    end else if (mac_busy && mb_r[0]) begin
      acc_r <= msub_r ? acc_r - $signed(ma_r) : acc_r + $signed(ma_r);
    end
  end

  // Latch intermediate fit terms
  always_ff @(posedge clk) begin
    if (op_go) begin
      unique case (op)
        lsf_pkg::OP_SAVE_D: begin
          d_r <= acc_r[lsf_pkg::DN_W-1:0];
        end
        lsf_pkg::OP_SAVE_N: begin
          nneg_r <= acc_r[lsf_pkg::ACC_W-1];
          nmag_r <= acc_abs[lsf_pkg::MAG_W-1:0];
        end
        lsf_pkg::OP_SAVE_T: begin
          t_r <= acc_r[lsf_pkg::B_W-1:0];
        end
        lsf_pkg::OP_SAVE_NUM: begin
          num_neg_r <= acc_r[lsf_pkg::ACC_W-1];
          num_mag_r <= acc_abs[lsf_pkg::NUM_W-1:0];
        end
        lsf_pkg::OP_SAVE_DIV: begin
          dvs_r <= acc_r[lsf_pkg::DV_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  assign div_start = op_go && (op == lsf_pkg::OP_DIV);

  lsf_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (num_mag_r),
    .den   (dvs_r),
    .busy  (div_busy),
    .quo   (quo)
  );

  // Truncated quotient, saturated to the 16-bit column range
  always_comb begin
    res_neg = num_neg_r ^ nneg_r;
    if (!res_neg) begin
      x_sat = (quo > lsf_pkg::NUM_W'(lsf_pkg::X_POS_MAX)) ?
              lsf_pkg::XOUT_W'(lsf_pkg::X_POS_MAX) : quo[lsf_pkg::XOUT_W-1:0];
    end else begin
      x_sat = (quo > lsf_pkg::NUM_W'(lsf_pkg::X_NEG_MAG)) ?
              lsf_pkg::XOUT_W'(lsf_pkg::X_NEG_MAG) :
              lsf_pkg::XOUT_W'(~quo[lsf_pkg::XOUT_W-1:0] + 1'b1);
    end
  end

  // Record found flags and lane columns per side
  always_ff @(posedge clk) begin
    if (op_go && op == lsf_pkg::OP_CHECK) begin
      found_r[cmd.side]    <= !status.skip;
      xres_r[cmd.side][0]  <= '0;
      xres_r[cmd.side][1]  <= '0;
    end else if (op_go && op == lsf_pkg::OP_STORE) begin
      xres_r[cmd.side][cmd.fit.row_top] <= x_sat;
    end
  end

  // Result register, free again once the result is taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_r.right_found     <= found_r[0];
      out_r.right_x_bottom  <= xres_r[0][0];
      out_r.right_x_top     <= xres_r[0][1];
      out_r.left_found      <= found_r[1];
      out_r.left_x_bottom   <= xres_r[1][0];
      out_r.left_x_top      <= xres_r[1][1];
      out_r.points_overflow <= ovf_r;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_data        = out_r;
  assign status.last     = in_r.frame_last;
  assign status.busy     = mac_busy || div_busy;
  assign status.skip     = (n_sel == '0) || (d_r == '0) || (nmag_r == '0);
  assign status.out_free = !out_valid_r || !out_stall;

endmodule

[src/lsf_ctrl.sv]
`timescale 1ns / 1ps
`include "assert_macros.svh"
// ----------------------------------------------------------------------------
// lsf_ctrl
// Controller: request intake, fit program sequencing and result release.
// ----------------------------------------------------------------------------
module lsf_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  lsf_pkg::dp_status_t  status,
  output lsf_pkg::ctrl_cmd_t   cmd
);

  lsf_pkg::ctrl_state_t         state_r, state_nxt;
  logic [lsf_pkg::STEP_W-1:0]   step_r, step_nxt;
  logic                         side_r, side_nxt;
  lsf_pkg::fit_cmd_t            cur;
  logic                         side_end, is_long;

  assign cur      = lsf_pkg::prog_cmd(step_r);
  assign is_long  = (cur.op == lsf_pkg::OP_MUL) || (cur.op == lsf_pkg::OP_DIV);
  assign side_end = (step_r == lsf_pkg::STEP_W'(lsf_pkg::STEP_LAST)) ||
                    ((step_r == lsf_pkg::STEP_W'(lsf_pkg::STEP_CHECK)) && status.skip);

  // Next state
  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    side_nxt  = side_r;
    unique case (state_r)
      lsf_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_nxt = lsf_pkg::ST_CLASSIFY;
        end
      end
      lsf_pkg::ST_CLASSIFY: begin
        step_nxt  = '0;
        side_nxt  = 1'b0;
        state_nxt = status.last ? lsf_pkg::ST_ISSUE : lsf_pkg::ST_IDLE;
      end
      lsf_pkg::ST_ISSUE, lsf_pkg::ST_WAIT: begin
        if (state_r == lsf_pkg::ST_ISSUE && is_long) begin
          state_nxt = lsf_pkg::ST_WAIT;
        end else if (state_r == lsf_pkg::ST_WAIT && status.busy) begin
          state_nxt = lsf_pkg::ST_WAIT;
        end else if (side_end) begin
          step_nxt  = '0;
          side_nxt  = 1'b1;
          state_nxt = side_r ? lsf_pkg::ST_DONE : lsf_pkg::ST_ISSUE;
        end else begin
          step_nxt  = step_r + 1'b1;
          state_nxt = lsf_pkg::ST_ISSUE;
        end
      end
      lsf_pkg::ST_DONE: begin
        if (status.out_free) begin
          state_nxt = lsf_pkg::ST_IDLE;
        end
      end
      default: state_nxt = lsf_pkg::ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    cmd          = '0;
    cmd.fit      = cur;
    cmd.side     = side_r;
    in_stall     = (state_r != lsf_pkg::ST_IDLE);
    unique case (state_r)
      lsf_pkg::ST_IDLE:     cmd.load_in  = in_valid;
      lsf_pkg::ST_CLASSIFY: cmd.classify = 1'b1;
      lsf_pkg::ST_ISSUE:    cmd.fit_go   = 1'b1;
      lsf_pkg::ST_WAIT:     cmd.fit_go   = 1'b0;
      lsf_pkg::ST_DONE:     cmd.emit     = status.out_free;
      default:              cmd.fit_go   = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= lsf_pkg::ST_IDLE;
      step_r  <= '0;
      side_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
      side_r  <= side_nxt;
    end
  end

  `LSF_ASSERT(a_accept_classify, (in_valid && !in_stall) |=> (state_r == lsf_pkg::ST_CLASSIFY), "accepted request not classified")
  `LSF_ASSERT(a_step_range, (step_r <= lsf_pkg::STEP_W'(lsf_pkg::STEP_LAST)), "fit step out of range")
  `LSF_ASSERT(a_done_idle, (state_r == lsf_pkg::ST_DONE && status.out_free) |=> (state_r == lsf_pkg::ST_IDLE), "result release did not return to idle")
  `LSF_ASSERT_ALWAYS(a_reset_idle, !rst_n |=> (state_r == lsf_pkg::ST_IDLE), "reset did not idle the controller")

endmodule

[src/lane_segment_line_fit.sv]
`timescale 1ns / 1ps
// A segment is accepted in the idle state, then filtered and accumulated in the classify state.
// No new segment is taken before the last one is through; the last segment of a frame adds the
//   fit, paced by the shift-add multiply-accumulate unit
//   (one multiplier bit a cycle) and the one-bit-a-cycle divider.
// Reset (synchronous, rst_n low): registers to defaults, sums and flags cleared.
// ----------------------------------------------------------------------------
// lane_segment_line_fit
// Least-squares lane line fit over the line segments of one frame.
// ----------------------------------------------------------------------------
module lane_segment_line_fit (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  lsf_pkg::in_item_t           in_data,
  output logic                        out_valid,
  input  logic                        out_stall,
  output lsf_pkg::out_item_t          out_data,
  input  logic                        cfg_psel,
  input  logic                        cfg_penable,
  input  logic                        cfg_pwrite,
  input  logic [lsf_pkg::CFG_AW-1:0]  cfg_paddr,
  input  logic [lsf_pkg::CFG_DW-1:0]  cfg_pwdata,
  output logic [lsf_pkg::CFG_DW-1:0]  cfg_prdata,
  output logic                        cfg_pready
);

  lsf_pkg::cfg_t       cfg;
  lsf_pkg::ctrl_cmd_t  cmd;
  lsf_pkg::dp_status_t status;

  lsf_cfg u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .cfg         (cfg)
  );

  lsf_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  lsf_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cfg       (cfg),
    .cmd       (cmd),
    .out_stall (out_stall),
    .status    (status),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule
